// ===== hw/rtl/alarm_code_to_id_encoder_top_assert.svh =====
// Assertion macros used by the alarm code encoder checker.
`ifndef ALARM_CODE_TO_ID_ENCODER_TOP_ASSERT_SVH
`define ALARM_CODE_TO_ID_ENCODER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define AC2ID_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define AC2ID_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/ac2id_pkg.sv =====
// Types and constants of the alarm code to ID encoder.
package ac2id_pkg;

    localparam int CHAR_W    = 8;
    localparam int ID_W      = 30;
    localparam int CLASS_W   = 4;
    localparam int VALUE_W   = 17;
    localparam int PAYLOAD_W = 27;
    localparam int HASH_W    = 32;
    localparam int QUOT_W    = 6;

    localparam logic [HASH_W-1:0]  CLASS_SCALE = 32'd100000000;
    // floor(2^32 / 1e8); the estimate it gives is exact or one low
    localparam logic [QUOT_W-1:0]  HASH_RECIP  = QUOT_W'((64'd1 << HASH_W) / 64'd100000000);
    localparam logic [VALUE_W-1:0] TAIL_SPLIT  = 17'd10000;

    localparam logic [CHAR_W-1:0] CHAR_0 = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_4 = 8'h34;
    localparam logic [CHAR_W-1:0] CHAR_8 = 8'h38;
    localparam logic [CHAR_W-1:0] CHAR_9 = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_A = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_E = 8'h45;
    localparam logic [CHAR_W-1:0] CHAR_J = 8'h4A;
    localparam logic [CHAR_W-1:0] CHAR_M = 8'h4D;
    localparam logic [CHAR_W-1:0] CHAR_R = 8'h52;
    localparam logic [CHAR_W-1:0] CHAR_S = 8'h53;
    localparam logic [CHAR_W-1:0] CHAR_W_ = 8'h57;

    localparam logic [1:0] PFX_NONE = 2'd0;
    localparam logic [1:0] PFX_JAM  = 2'd1;
    localparam logic [1:0] PFX_WAR  = 2'd2;
    localparam logic [1:0] PFX_MES  = 2'd3;

    localparam logic [CLASS_W-1:0] CLS_HASH = 4'd9;

    // Finished code, as it leaves the accumulator
    typedef struct packed {
        logic [CLASS_W-1:0] cls;
        logic               is_hash;
        logic [VALUE_W-1:0] payload;
        logic [HASH_W-1:0]  hash;
    } fin_t;

    // Finished code with its quotient estimate
    typedef struct packed {
        fin_t              fin;
        logic [QUOT_W-1:0] quot;
    } quot_t;

    // Class and payload, ready for final scaling
    typedef struct packed {
        logic [CLASS_W-1:0]   cls;
        logic [PAYLOAD_W-1:0] payload;
    } res_t;

endpackage

// ===== hw/rtl/ac2id_in_if.sv =====
// Input channel: one code byte per transaction.
interface ac2id_in_if;
    import ac2id_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] code_char;
    logic              last_char;

    modport source (output valid, output code_char, output last_char, input ready);
    modport sink   (input valid, input code_char, input last_char, output ready);
endinterface

// ===== hw/rtl/ac2id_out_if.sv =====
// Output channel: one alarm ID per transaction.
interface ac2id_out_if;
    import ac2id_pkg::*;

    logic               valid;
    logic               ready;
    logic [ID_W-1:0]    alarm_id;
    logic [CLASS_W-1:0] alarm_class;

    modport source (output valid, output alarm_id, output alarm_class, input ready);
    modport sink   (input valid, input alarm_id, input alarm_class, output ready);
endinterface

// ===== hw/rtl/alarm_code_to_id_encoder_top.sv =====
// Alarm code to ID encoder: top level with the output register.
//
// Takes an alarm code string one byte per transaction on code_in, with
// last_char set on the final byte, and after that byte delivers one
// nine-digit alarm ID on id_out. JAM/WAR/MES codes of 7 or 8 characters
// with a canonical 4- or 5-digit tail give class 1/2/3 plus the tail value;
// five-digit numbers starting 4..8 give that digit as class plus the
// number; anything else gives class 9 plus a times-31 hash of the bytes
// modulo 1e8. Throughput is one byte per clock while code_in is ready,
// with no gaps between codes. A result is loaded into the accumulator
// register when its last byte is accepted, then passes through the quotient
// estimate register (hash times reciprocal of 1e8) and the remainder
// register to the id_out register that adds class times 1e8. Every stage
// has its own valid and advances whenever the stage after it is empty or
// emptying, so bytes keep flowing while a finished ID waits to be taken;
// code_in only stalls once all result stages hold unclaimed transactions.
module alarm_code_to_id_encoder_top (
    input  logic       clk,
    input  logic       rst_n,
    ac2id_in_if.sink   code_in,
    ac2id_out_if.source id_out
);
    import ac2id_pkg::*;

    logic               fin_valid;
    fin_t               fin;
    logic               fin_ready;
    logic               res_valid;
    res_t               res;
    logic               res_ready;

    logic               out_valid_reg, out_valid_next;
    logic [ID_W-1:0]    id_reg,        id_next;
    logic [CLASS_W-1:0] class_reg,     class_next;

    // byte accumulation and classification
    ac2id_accum u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .code_in   (code_in),
        .fin_valid (fin_valid),
        .fin       (fin),
        .fin_ready (fin_ready)
    );

    // hash reduction modulo 1e8
    ac2id_hash_mod u_hash_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .fin_valid (fin_valid),
        .fin       (fin),
        .fin_ready (fin_ready),
        .res_valid (res_valid),
        .res       (res),
        .res_ready (res_ready)
    );

    // output register: ID = class * 1e8 + payload
    assign res_ready = !out_valid_reg || id_out.ready;

    always_comb
    begin
        id_next        = ID_W'(HASH_W'(res.cls) * CLASS_SCALE) + ID_W'(res.payload);
        class_next     = res.cls;
        out_valid_next = res_ready ? res_valid : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            id_reg    <= id_next;
            class_reg <= class_next;
        end
    end

    assign id_out.valid       = out_valid_reg;
    assign id_out.alarm_id    = id_reg;
    assign id_out.alarm_class = class_reg;
endmodule

// ===== hw/rtl/ac2id_accum.sv =====
// Per-byte accumulator and classifier; registers the finished code.
module ac2id_accum (
    input  logic         clk,
    input  logic         rst_n,
    ac2id_in_if.sink     code_in,
    output logic         fin_valid,
    output ac2id_pkg::fin_t fin,
    input  logic         fin_ready
);
    import ac2id_pkg::*;

    logic [HASH_W-1:0]  hash_reg,      hash_next;
    logic [3:0]         count_reg,     count_next;
    logic [15:0]        first_two_reg, first_two_next;
    logic [1:0]         prefix_reg,    prefix_next;
    logic [VALUE_W-1:0] tail_reg,      tail_next;
    logic [VALUE_W-1:0] whole_reg,     whole_next;
    logic               tail_ok_reg,   tail_ok_next;
    logic               all_ok_reg,    all_ok_next;
    logic               fin_valid_reg, fin_valid_next;
    fin_t               fin_reg,       fin_next;

    logic [CHAR_W-1:0]  c;
    logic [3:0]         n;
    logic [3:0]         digit;
    logic               is_dig;
    logic               take;
    logic               prefixed_ok;
    logic               numeric_ok;

    assign code_in.ready = !fin_valid_reg || fin_ready;
    assign take          = code_in.valid && code_in.ready;
    assign c             = code_in.code_char;
    assign is_dig        = (c >= CHAR_0) && (c <= CHAR_9);
    assign digit         = c[3:0];      // ASCII digits carry their value in the low nibble
    assign n             = (count_reg >= 4'd9) ? 4'd9 : count_reg + 4'd1;

    always_comb
    begin
        // h*31 + c as a shift and subtract
        hash_next      = (hash_reg << 5) - hash_reg + HASH_W'(c);
        count_next     = n;
        first_two_next = first_two_reg;
        prefix_next    = prefix_reg;
        tail_next      = tail_reg;
        whole_next     = whole_reg;
        tail_ok_next   = tail_ok_reg;
        all_ok_next    = all_ok_reg;

        if (n == 4'd1)
        begin
            first_two_next = {c, 8'h00};
        end
        else if (n == 4'd2)
        begin
            first_two_next = {first_two_reg[15:8], c};
        end
        else if (n == 4'd3)
        begin
            if (first_two_reg == {CHAR_J, CHAR_A} && c == CHAR_M)
                prefix_next = PFX_JAM;
            else if (first_two_reg == {CHAR_W_, CHAR_A} && c == CHAR_R)
                prefix_next = PFX_WAR;
            else if (first_two_reg == {CHAR_M, CHAR_E} && c == CHAR_S)
                prefix_next = PFX_MES;
            else
                prefix_next = PFX_NONE;
        end

        if (n >= 4'd4 && n <= 4'd8)
        begin
            if (!is_dig)
                tail_ok_next = 1'b0;
            else if (tail_ok_reg)
                tail_next = (tail_reg << 3) + (tail_reg << 1) + VALUE_W'(digit);
        end
        if (n <= 4'd5)
        begin
            if (!is_dig)
                all_ok_next = 1'b0;
            else if (all_ok_reg)
                whole_next = (whole_reg << 3) + (whole_reg << 1) + VALUE_W'(digit);
        end

        prefixed_ok = ((n == 4'd7 && tail_next < TAIL_SPLIT) ||
                       (n == 4'd8 && tail_next >= TAIL_SPLIT)) &&
                      prefix_next != PFX_NONE && tail_ok_next;
        numeric_ok  = (n == 4'd5) && all_ok_next &&
                      first_two_next[15:8] >= CHAR_4 && first_two_next[15:8] <= CHAR_8;

        fin_next.hash = hash_next;
        if (prefixed_ok)
        begin
            fin_next.cls     = {2'b00, prefix_next};
            fin_next.is_hash = 1'b0;
            fin_next.payload = tail_next;
        end
        else if (numeric_ok)
        begin
            fin_next.cls     = first_two_next[11:8];
            fin_next.is_hash = 1'b0;
            fin_next.payload = whole_next;
        end
        else
        begin
            fin_next.cls     = CLS_HASH;
            fin_next.is_hash = 1'b1;
            fin_next.payload = '0;
        end

        fin_valid_next = code_in.ready ? (code_in.valid && code_in.last_char) : fin_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg      <= '0;
            count_reg     <= '0;
            first_two_reg <= '0;
            prefix_reg    <= PFX_NONE;
            tail_reg      <= '0;
            whole_reg     <= '0;
            tail_ok_reg   <= 1'b1;
            all_ok_reg    <= 1'b1;
            fin_valid_reg <= 1'b0;
        end
        else
        begin
            fin_valid_reg <= fin_valid_next;
            if (take && code_in.last_char)
            begin
                hash_reg      <= '0;
                count_reg     <= '0;
                first_two_reg <= '0;
                prefix_reg    <= PFX_NONE;
                tail_reg      <= '0;
                whole_reg     <= '0;
                tail_ok_reg   <= 1'b1;
                all_ok_reg    <= 1'b1;
            end
            else if (take)
            begin
                hash_reg      <= hash_next;
                count_reg     <= count_next;
                first_two_reg <= first_two_next;
                prefix_reg    <= prefix_next;
                tail_reg      <= tail_next;
                whole_reg     <= whole_next;
                tail_ok_reg   <= tail_ok_next;
                all_ok_reg    <= all_ok_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && code_in.last_char)
            fin_reg <= fin_next;
    end

    assign fin_valid = fin_valid_reg;
    assign fin       = fin_reg;
endmodule

// ===== hw/rtl/ac2id_hash_mod.sv =====
// Two-stage hash mod 1e8: reciprocal quotient estimate, then remainder with one fix-up.
module ac2id_hash_mod (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            fin_valid,
    input  ac2id_pkg::fin_t fin,
    output logic            fin_ready,
    output logic            res_valid,
    output ac2id_pkg::res_t res,
    input  logic            res_ready
);
    import ac2id_pkg::*;

    logic                    q_valid_reg, q_valid_next;
    quot_t                   q_reg,       q_next;
    logic                    r_valid_reg, r_valid_next;
    res_t                    r_reg,       r_next;

    logic                    q_ready;
    logic                    r_ready;
    logic [HASH_W+QUOT_W-1:0] prod;
    logic [HASH_W-1:0]       rem0;
    logic [HASH_W-1:0]       rem1;

    assign r_ready   = !r_valid_reg || res_ready;
    assign q_ready   = !q_valid_reg || r_ready;
    assign fin_ready = q_ready;

    always_comb
    begin
        prod         = (HASH_W+QUOT_W)'(fin.hash) * (HASH_W+QUOT_W)'(HASH_RECIP);
        q_next.fin   = fin;
        q_next.quot  = prod[HASH_W+QUOT_W-1:HASH_W];
        q_valid_next = q_ready ? fin_valid : q_valid_reg;
    end

    always_comb
    begin
        // estimate is exact or one low, so the remainder is below 2e8
        rem0 = q_reg.fin.hash - HASH_W'(HASH_W'(q_reg.quot) * CLASS_SCALE);
        rem1 = (rem0 >= CLASS_SCALE) ? rem0 - CLASS_SCALE : rem0;
        r_next.cls = q_reg.fin.cls;
        if (q_reg.fin.is_hash)
            r_next.payload = rem1[PAYLOAD_W-1:0];
        else
            r_next.payload = PAYLOAD_W'(q_reg.fin.payload);
        r_valid_next = r_ready ? q_valid_reg : r_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_valid_reg <= 1'b0;
            r_valid_reg <= 1'b0;
        end
        else
        begin
            q_valid_reg <= q_valid_next;
            r_valid_reg <= r_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fin_valid && q_ready)
            q_reg <= q_next;
        if (q_valid_reg && r_ready)
            r_reg <= r_next;
    end

    assign res_valid = r_valid_reg;
    assign res       = r_reg;
endmodule

// ===== hw/rtl/ac2id_chk.sv =====
// Port-level checker for the alarm code encoder, bound to the top level.
`include "alarm_code_to_id_encoder_top_assert.svh"

module ac2id_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [29:0] alarm_id,
    input logic [3:0]  alarm_class
);
    import ac2id_pkg::*;

    logic [29:0] base;
    logic [29:0] payload;
    logic [33:0] id_word;
    logic        stalled;
    logic        in_window;
    logic        is_hashed;
    logic        short_ok;
    logic        is_numeric;
    logic [29:0] lead_lo;
    logic        lead_ok;

    assign base       = 30'(alarm_class) * 30'd100000000;
    assign payload    = alarm_id - base;
    assign id_word    = {alarm_class, alarm_id};
    assign stalled    = out_valid && !out_ready;
    assign in_window  = alarm_class >= 4'd1 && alarm_class <= 4'd9 &&
                        alarm_id >= base && payload < 30'd100000000;
    assign is_hashed  = (alarm_class == CLS_HASH);
    assign short_ok   = payload <= 30'd99999;
    assign is_numeric = alarm_class >= 4'd4 && alarm_class <= 4'd8;
    assign lead_lo    = 30'(alarm_class) * 30'd10000;
    assign lead_ok    = payload >= lead_lo && payload < lead_lo + 30'd10000;

    // held result must not change while stalled
    `AC2ID_ASSERT_NEXT(a_out_hold, stalled, out_valid && $stable(id_word), "held result changed")

    // ID carries its class as the leading digit
    `AC2ID_ASSERT_NOW(a_id_window, out_valid, in_window, "ID does not match class")

    // prefixed and numeric classes carry at most five digits
    `AC2ID_ASSERT_NOW(a_short_payload, out_valid && !is_hashed, short_ok, "payload too long")

    // numeric class equals the leading digit of the number
    `AC2ID_ASSERT_NOW(a_numeric_lead, out_valid && is_numeric, lead_ok, "numeric class mismatch")
endmodule

bind alarm_code_to_id_encoder_top ac2id_chk u_ac2id_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (id_out.valid),
    .out_ready   (id_out.ready),
    .alarm_id    (id_out.alarm_id),
    .alarm_class (id_out.alarm_class)
);
